FILE: design/interrupt_priority_controller_top_assert.svh
// ----------------------------------------------------------------------------
// interrupt priority controller assertion macros
// shared clocking and reset wrapper for the checks in the top level
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_PRIORITY_CONTROLLER_TOP_ASSERT_SVH
`define INTERRUPT_PRIORITY_CONTROLLER_TOP_ASSERT_SVH

// implication checked at every clock edge outside reset
`define IPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// types, constants and source tables of the interrupt priority controller
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int NUM_SOURCES = 27;
  localparam int IDX_W       = $clog2(NUM_SOURCES);
  localparam int PRIO_W      = 5;
  localparam int SUB_W       = 3;
  localparam int CODE_W      = 11;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int KEY_W       = 1 + PRIO_W + SUB_W + IDX_W;

  // input kinds
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_LEVEL = 2'd1;
  localparam logic [1:0] KIND_TAKE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_C = 2'd2;

  // where a source's priority comes from
  localparam logic [2:0] PSRC_FIXED = 3'd0;
  localparam logic [2:0] PSRC_EXT   = 3'd1;
  localparam logic [2:0] PSRC_A     = 3'd2;
  localparam logic [2:0] PSRC_B     = 3'd3;
  localparam logic [2:0] PSRC_C     = 3'd4;

  localparam logic [IDX_W-1:0]  IRL_IDX       = 5'd1;
  localparam logic [PRIO_W-1:0] NMI_PRIO      = 5'd16;
  localparam logic [3:0]        EXT_PRIO_RST  = 4'd1;
  localparam logic [CODE_W-1:0] EXT_CODE_BASE = 11'h200;

  localparam logic [2:0] PRIO_FROM [NUM_SOURCES] = '{
    PSRC_FIXED, PSRC_EXT, PSRC_C, PSRC_C, PSRC_C, PSRC_C, PSRC_C, PSRC_C, PSRC_C,
    PSRC_A, PSRC_A, PSRC_A, PSRC_A, PSRC_A, PSRC_A, PSRC_A,
    PSRC_B, PSRC_B, PSRC_B, PSRC_B, PSRC_C, PSRC_C, PSRC_C, PSRC_C,
    PSRC_B, PSRC_B, PSRC_B
  };

  localparam logic [3:0] PRIO_SHIFT [NUM_SOURCES] = '{
    4'd0, 4'd0, 4'd0, 4'd12, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd12, 4'd8, 4'd4, 4'd4, 4'd0, 4'd0, 4'd0,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd12, 4'd8, 4'd8
  };

  localparam logic [SUB_W-1:0] SUB_PRIO [NUM_SOURCES] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
    3'd0, 3'd0, 3'd4, 3'd0, 3'd2, 3'd1, 3'd0,
    3'd3, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2, 3'd1, 3'd0,
    3'd0, 3'd1, 3'd0
  };

  localparam logic [CODE_W-1:0] CODE_OF [NUM_SOURCES] = '{
    11'h1C0, 11'h200, 11'h600, 11'h620, 11'h640, 11'h660, 11'h680, 11'h6A0, 11'h6C0,
    11'h400, 11'h420, 11'h440, 11'h460, 11'h480, 11'h4A0, 11'h4C0,
    11'h4E0, 11'h500, 11'h520, 11'h540, 11'h700, 11'h720, 11'h740, 11'h760,
    11'h560, 11'h580, 11'h5A0
  };

  typedef logic [NUM_SOURCES-1:0][PRIO_W-1:0] prio_vec_t;
  typedef logic [KEY_W-1:0] key_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic fin;
  } ipc_cmd_t;

endpackage

FILE: design/ipc_arb.sv
// ----------------------------------------------------------------------------
// ipc_arb
// two-stage compare tree picking the best raised source
// ----------------------------------------------------------------------------
module ipc_arb (
  input  logic                              clk_i,
  input  logic [ipc_pkg::NUM_SOURCES-1:0]   raised_i,
  input  ipc_pkg::prio_vec_t                prio_i,
  output logic                              win_valid_o,
  output logic [ipc_pkg::IDX_W-1:0]         win_idx_o,
  output logic [ipc_pkg::PRIO_W-1:0]        win_prio_o
);
  import ipc_pkg::*;

  localparam int GRP_N = 4;
  localparam int GRP_SZ = (NUM_SOURCES + GRP_N - 1) / GRP_N;

  key_t grp_d [GRP_N];
  key_t grp_q [GRP_N];
  key_t best;

  // key orders by valid, priority, sub-priority, then lower source number
  always_comb begin
    key_t k;
    for (int g = 0; g < GRP_N; g++) begin
      grp_d[g] = '0;
      for (int m = 0; m < GRP_SZ; m++) begin
        if (g * GRP_SZ + m < NUM_SOURCES) begin
          k = {raised_i[g*GRP_SZ+m], prio_i[g*GRP_SZ+m], SUB_PRIO[g*GRP_SZ+m],
               IDX_W'(NUM_SOURCES - 1 - (g * GRP_SZ + m))};
          if (k > grp_d[g]) begin
            grp_d[g] = k;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    best = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (grp_q[g] > best) begin
        best = grp_q[g];
      end
    end
  end

  assign win_valid_o = best[KEY_W-1];
  assign win_prio_o  = best[IDX_W+SUB_W +: PRIO_W];
  assign win_idx_o   = IDX_W'(NUM_SOURCES - 1) - best[IDX_W-1:0];

endmodule

FILE: design/ipc_ctrl.sv
// ----------------------------------------------------------------------------
// ipc_ctrl
// sequencer: load command, execute, let the tree settle, report
// ----------------------------------------------------------------------------
module ipc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output ipc_pkg::ipc_cmd_t cmd_o
);
  import ipc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SETTLE = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start) state_d = S_EXEC;
      S_EXEC:   state_d = S_SETTLE;
      S_SETTLE: state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign cmd_o.load = (state_q == S_IDLE) && start;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign cmd_o.fin  = (state_q == S_FINISH);

endmodule

FILE: design/ipc_dp.sv
// ----------------------------------------------------------------------------
// ipc_dp
// source flags, external level, priority words and result registers
// ----------------------------------------------------------------------------
module ipc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ipc_pkg::ipc_cmd_t                 cmd_i,
  input  logic [1:0]                        kind_i,
  input  logic [4:0]                        source_index_i,
  input  logic                              raise_flag_i,
  input  logic [3:0]                        ext_level_i,
  input  logic                              cfg_we_i,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ipc_pkg::CFG_W-1:0]         cfg_data_i,
  output logic [ipc_pkg::PRIO_W-1:0]        highest_priority_o,
  output logic [ipc_pkg::CODE_W-1:0]        event_code_o,
  output logic                              taken_o,
  output logic                              no_source_o,
  output logic                              done_o
);
  import ipc_pkg::*;

  logic [CFG_W-1:0]       prio_a_q, prio_b_q, prio_c_q;
  logic [NUM_SOURCES-1:0] raised_q, raised_d;
  logic [3:0]             ext_prio_q, ext_prio_d;
  logic [CODE_W-1:0]      ext_code_q, ext_code_d;

  logic [1:0]             kind_q;
  logic [4:0]             src_q;
  logic                   flag_q;
  logic [3:0]             level_q;

  logic [PRIO_W-1:0]      hp_q;
  logic [CODE_W-1:0]      code_q, code_d;
  logic                   taken_q, taken_d;
  logic                   none_q, none_d;
  logic                   done_q;

  prio_vec_t              prio;
  logic                   win_valid;
  logic [IDX_W-1:0]       win_idx;
  logic [PRIO_W-1:0]      win_prio;

  // per-source priority
  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      case (PRIO_FROM[i])
        PSRC_FIXED: prio[i] = NMI_PRIO;
        PSRC_EXT:   prio[i] = {1'b0, ext_prio_q};
        PSRC_A:     prio[i] = {1'b0, 4'(prio_a_q >> PRIO_SHIFT[i])};
        PSRC_B:     prio[i] = {1'b0, 4'(prio_b_q >> PRIO_SHIFT[i])};
        default:    prio[i] = {1'b0, 4'(prio_c_q >> PRIO_SHIFT[i])};
      endcase
    end
  end

  ipc_arb u_arb (
    .clk_i       (clk_i),
    .raised_i    (raised_q),
    .prio_i      (prio),
    .win_valid_o (win_valid),
    .win_idx_o   (win_idx),
    .win_prio_o  (win_prio)
  );

  always_comb begin
    raised_d   = raised_q;
    ext_prio_d = ext_prio_q;
    ext_code_d = ext_code_q;
    code_d     = code_q;
    taken_d    = taken_q;
    none_d     = none_q;
    if (cmd_i.exec) begin
      code_d  = '0;
      taken_d = 1'b0;
      none_d  = 1'b0;
      case (kind_q)
        KIND_SET: begin
          if (src_q < IDX_W'(NUM_SOURCES)) begin
            raised_d[src_q] = flag_q;
          end
        end
        KIND_LEVEL: begin
          ext_prio_d        = ~level_q;
          ext_code_d        = EXT_CODE_BASE + {2'b00, level_q, 5'b00000};
          raised_d[IRL_IDX] = (level_q != 4'hF);
        end
        KIND_TAKE: begin
          if (win_valid) begin
            taken_d = 1'b1;
            code_d  = (win_idx == IRL_IDX) ? ext_code_q : CODE_OF[win_idx];
            // a take does not clear the external line; a level or set command changes it
            if (win_idx != IRL_IDX) begin
              raised_d[win_idx] = 1'b0;
            end
          end else begin
            none_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_a_q   <= '0;
      prio_b_q   <= '0;
      prio_c_q   <= '0;
      raised_q   <= '0;
      ext_prio_q <= EXT_PRIO_RST;
      ext_code_q <= EXT_CODE_BASE;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PRIO_A: prio_a_q <= cfg_data_i;
          REG_PRIO_B: prio_b_q <= cfg_data_i;
          REG_PRIO_C: prio_c_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      raised_q   <= raised_d;
      ext_prio_q <= ext_prio_d;
      ext_code_q <= ext_code_d;
      done_q     <= cmd_i.fin;
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      src_q   <= source_index_i;
      flag_q  <= raise_flag_i;
      level_q <= ext_level_i;
    end
    code_q  <= code_d;
    taken_q <= taken_d;
    none_q  <= none_d;
    if (cmd_i.fin) begin
      hp_q <= win_valid ? win_prio : '0;
    end
  end

  assign highest_priority_o = hp_q;
  assign event_code_o       = code_q;
  assign taken_o            = taken_q;
  assign no_source_o        = none_q;
  assign done_o             = done_q;

endmodule

FILE: design/interrupt_priority_controller_top.sv
// ----------------------------------------------------------------------------
// interrupt_priority_controller_top
// 27-source interrupt priority controller with raise, level and take commands
// ----------------------------------------------------------------------------
// usage:
//   a command is transferred when start is high and busy is low; it carries
//   kind_i, source_index_i, raise_flag_i and ext_level_i
//   busy stays high after the transfer while the command is applied (S_EXEC)
//   and the registered compare tree settles on the new flags (S_SETTLE,
//   S_FINISH); a take uses the tree's answer in the apply state
//   done_o then pulses for one cycle with highest_priority_o, event_code_o,
//   taken_o and no_source_o valid; busy is already low in that cycle, so a
//   new command may be transferred alongside it
//   no new command is taken while busy is high; the two-stage compare tree
//   over the 27 sources is what keeps the sequencer busy
//   the receiver cannot stall; results hold until the next command updates them
//   priority words are written through cfg_we_i, cfg_idx_i and cfg_data_i
//   by the user only while idle (not enforced by the block), taking effect at once
//   reset clears all flags and priority words, external priority 1, code 0x200
// ----------------------------------------------------------------------------
module interrupt_priority_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic [4:0]                    source_index_i,
  input  logic                          raise_flag_i,
  input  logic [3:0]                    ext_level_i,
  output logic                          done_o,
  output logic [ipc_pkg::PRIO_W-1:0]    highest_priority_o,
  output logic [ipc_pkg::CODE_W-1:0]    event_code_o,
  output logic                          taken_o,
  output logic                          no_source_o,
  input  logic                          cfg_we_i,
  input  logic [ipc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ipc_pkg::CFG_W-1:0]     cfg_data_i
);
  import ipc_pkg::*;

  ipc_cmd_t cmd;

  ipc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  ipc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .kind_i             (kind_i),
    .source_index_i     (source_index_i),
    .raise_flag_i       (raise_flag_i),
    .ext_level_i        (ext_level_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .highest_priority_o (highest_priority_o),
    .event_code_o       (event_code_o),
    .taken_o            (taken_o),
    .no_source_o        (no_source_o),
    .done_o             (done_o)
  );

`include "interrupt_priority_controller_top_assert.svh"

  `IPC_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done_o, "transfer did not raise busy")
  `IPC_ASSERT_IMPLY(a_done_idle, done_o, !busy, "result shown while busy")
  `IPC_ASSERT_IMPLY(a_take_excl, done_o, !(taken_o && no_source_o), "taken and no source both set")
  `IPC_ASSERT_IMPLY(a_code_zero, done_o && !taken_o, event_code_o == '0, "code without a take")

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for interrupt_priority_controller_top: a queue-fed
// driver issues raise, level and take commands with random gaps, a monitor
// predicts each result from its own model of the flags, priority words and
// external level, and compares every done strobe against the oldest
// prediction
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipc_pkg::*;

  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam int         CYCLE_LIMIT = 100000;
  localparam int         ITEMS_PER_PHASE = 140;
  localparam int         RANDOM_PHASES   = 8;

  localparam logic [2:0] SRC_SUB [NUM_SOURCES] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
    3'd0, 3'd0, 3'd4, 3'd0, 3'd2, 3'd1, 3'd0,
    3'd3, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2, 3'd1, 3'd0,
    3'd0, 3'd1, 3'd0
  };

  localparam logic [10:0] SRC_CODE [NUM_SOURCES] = '{
    11'h1C0, 11'h200, 11'h600, 11'h620, 11'h640, 11'h660, 11'h680, 11'h6A0, 11'h6C0,
    11'h400, 11'h420, 11'h440, 11'h460, 11'h480, 11'h4A0, 11'h4C0,
    11'h4E0, 11'h500, 11'h520, 11'h540, 11'h700, 11'h720, 11'h740, 11'h760,
    11'h560, 11'h580, 11'h5A0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] src;
    logic       flag;
    logic [3:0] level;
  } irq_cmd_t;

  typedef struct packed {
    logic [4:0]  prio;
    logic [10:0] code;
    logic        taken;
    logic        none;
  } irq_result_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic [1:0]           kind_i         = '0;
  logic [4:0]           source_index_i = '0;
  logic                 raise_flag_i   = 1'b0;
  logic [3:0]           ext_level_i    = '0;
  logic                 done_o;
  logic [PRIO_W-1:0]    highest_priority_o;
  logic [CODE_W-1:0]    event_code_o;
  logic                 taken_o;
  logic                 no_source_o;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [CFG_W-1:0]     cfg_data_i     = '0;

  interrupt_priority_controller_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .source_index_i    (source_index_i),
    .raise_flag_i      (raise_flag_i),
    .ext_level_i       (ext_level_i),
    .done_o            (done_o),
    .highest_priority_o(highest_priority_o),
    .event_code_o      (event_code_o),
    .taken_o           (taken_o),
    .no_source_o       (no_source_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  // controller model
  logic [NUM_SOURCES-1:0] raised;
  logic [3:0]             ext_prio;
  logic [10:0]            ext_code;
  logic [15:0]            word_a, word_b, word_c;

  irq_cmd_t    cmd_queue[$];
  irq_result_t pending_results[$];
  irq_cmd_t    next_cmd;
  logic        cmd_taken   = 1'b0;
  bit          gaps_on     = 1'b1;
  int          gap_left    = 0;
  int          err_count   = 0;
  int          cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void model_reset();
    raised   = '0;
    ext_prio = 4'd1;
    ext_code = 11'h200;
    word_a   = '0;
    word_b   = '0;
    word_c   = '0;
  endfunction

  function automatic logic [4:0] src_priority(int idx);
    case (idx)
      0:              return 5'd16;
      1:              return {1'b0, ext_prio};
      2:              return {1'b0, word_c[3:0]};
      3:              return {1'b0, word_c[15:12]};
      4, 5, 6, 7, 8:  return {1'b0, word_c[11:8]};
      9:              return {1'b0, word_a[15:12]};
      10:             return {1'b0, word_a[11:8]};
      11, 12:         return {1'b0, word_a[7:4]};
      13, 14, 15:     return {1'b0, word_a[3:0]};
      16, 17, 18, 19: return {1'b0, word_b[7:4]};
      20, 21, 22, 23: return {1'b0, word_c[7:4]};
      24:             return {1'b0, word_b[15:12]};
      default:        return {1'b0, word_b[11:8]};
    endcase
  endfunction

  // highest priority, then highest sub-priority, then lowest source number
  function automatic int pick_winner();
    int         best;
    logic [4:0] bp;
    logic [4:0] p;
    logic [2:0] bs;
    best = -1;
    bp   = '0;
    bs   = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (raised[i]) begin
        p = src_priority(i);
        if (best < 0 || p > bp || (p == bp && SRC_SUB[i] > bs)) begin
          best = i;
          bp   = p;
          bs   = SRC_SUB[i];
        end
      end
    end
    return best;
  endfunction

  function automatic void apply_command(irq_cmd_t c);
    int          w;
    irq_result_t r;
    r = '0;
    case (c.kind)
      KIND_SET: begin
        if (c.src < NUM_SOURCES) raised[c.src] = c.flag;
      end
      KIND_LEVEL: begin
        ext_prio  = ~c.level;
        ext_code  = 11'h200 + {c.level, 5'b0};
        raised[1] = (ext_prio != 4'd0);
      end
      KIND_TAKE: begin
        w = pick_winner();
        if (w < 0) begin
          r.none = 1'b1;
        end else begin
          r.taken = 1'b1;
          r.code  = (w == 1) ? ext_code : SRC_CODE[w];
          // a take does not clear the external line; only a level or set command changes it
          if (w != 1) raised[w] = 1'b0;
        end
      end
      default: ;
    endcase
    w      = pick_winner();
    r.prio = (w < 0) ? 5'd0 : src_priority(w);
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (err_count < 50)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", field, got, want, cycle_count);
    err_count++;
  endtask

  task automatic check_result();
    irq_result_t e;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", 1, 0);
    end else begin
      e = pending_results.pop_front();
      if (highest_priority_o !== e.prio) report_mismatch("highest_priority", highest_priority_o, e.prio);
      if (event_code_o !== e.code)       report_mismatch("event_code", event_code_o, e.code);
      if (taken_o !== e.taken)           report_mismatch("taken", taken_o, e.taken);
      if (no_source_o !== e.none)        report_mismatch("no_source", no_source_o, e.none);
    end
  endtask

  // monitor and predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PRIO_A: word_a = cfg_data_i;
          REG_PRIO_B: word_b = cfg_data_i;
          REG_PRIO_C: word_c = cfg_data_i;
          default: ;
        endcase
      end
      // a result may share the edge with the next transfer, so check first
      if (done_o) check_result();
      if (start && !busy) apply_command('{kind_i, source_index_i, raise_flag_i, ext_level_i});
      cmd_taken <= start && !busy;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!start || cmd_taken)) begin
      if (gap_left == 0 && cmd_queue.size() > 0) begin
        next_cmd = cmd_queue.pop_front();
        kind_i         <= next_cmd.kind;
        source_index_i <= next_cmd.src;
        raise_flag_i   <= next_cmd.flag;
        ext_level_i    <= next_cmd.level;
        start          <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) gap_left = int'($urandom_range(1, 10));
      end else begin
        if (gap_left > 0) gap_left = gap_left - 1;
        // noise on the fields while nothing is offered
        kind_i         <= 2'($urandom_range(0, 3));
        source_index_i <= 5'($urandom_range(0, 31));
        raise_flag_i   <= 1'($urandom_range(0, 1));
        ext_level_i    <= 4'($urandom_range(0, 15));
        start          <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic queue_cmd(logic [1:0] kind, logic [4:0] src, logic flag, logic [3:0] level);
    cmd_queue.push_back('{kind, src, flag, level});
  endtask

  function automatic irq_cmd_t random_cmd();
    irq_cmd_t c;
    int       r;
    c.src   = 5'($urandom_range(0, 31));
    c.flag  = 1'($urandom_range(0, 1));
    c.level = 4'($urandom_range(0, 15));
    r = int'($urandom_range(0, 99));
    if (r < 45) begin
      c.kind = KIND_SET;
      if ($urandom_range(0, 9) != 0) c.src = 5'($urandom_range(0, NUM_SOURCES - 1));
      // lean towards raising so several sources compete
      c.flag = ($urandom_range(0, 99) < 65);
    end else if (r < 55) begin
      c.kind = KIND_LEVEL;
    end else if (r < 95) begin
      c.kind = KIND_TAKE;
    end else begin
      c.kind = KIND_NONE;
    end
    return c;
  endfunction

  function automatic logic [15:0] random_prio_word();
    logic [15:0] v;
    for (int n = 0; n < 4; n++) begin
      case ($urandom_range(0, 3))
        0:       v[n*4 +: 4] = 4'h0;
        1:       v[n*4 +: 4] = 4'hF;
        default: v[n*4 +: 4] = 4'($urandom_range(0, 15));
      endcase
    end
    return v;
  endfunction

  // sender holds off until every transfer has produced its result
  // sampled at the rising edge, where start and the queue are settled
  task automatic wait_idle();
    do @(posedge clk_i);
    while (cmd_queue.size() != 0 || start || pending_results.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_prio_words(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PRIO_A;
    cfg_data_i <= a;
    @(negedge clk_i);
    cfg_idx_i  <= REG_PRIO_B;
    cfg_data_i <= b;
    @(negedge clk_i);
    cfg_idx_i  <= REG_PRIO_C;
    cfg_data_i <= c;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    model_reset();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // priority words at reset: everything but nmi and the external line at zero
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);    // nothing raised
    queue_cmd(KIND_SET, 5'd9, 1'b1, 4'd0);     // priority zero source
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);
    queue_cmd(KIND_LEVEL, 5'd0, 1'b0, 4'd15);  // level drops the external line
    queue_cmd(KIND_LEVEL, 5'd0, 1'b0, 4'd0);   // highest external priority
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);    // external line stays raised
    queue_cmd(KIND_SET, 5'd1, 1'b0, 4'd0);     // clear external line directly
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);
    queue_cmd(KIND_SET, 5'd1, 1'b1, 4'd0);     // raise external line directly
    queue_cmd(KIND_SET, 5'd31, 1'b1, 4'd0);    // source out of range
    queue_cmd(KIND_NONE, 5'd0, 1'b1, 4'd9);    // unused kind
    queue_cmd(KIND_SET, 5'd0, 1'b1, 4'd0);     // nmi
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);
    queue_cmd(KIND_LEVEL, 5'd0, 1'b0, 4'd7);
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);
    wait_idle();

    // all fields at their maximum: sub-priority decides the takes below
    write_prio_words(16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int s = 4; s <= 8; s++) queue_cmd(KIND_SET, s[4:0], 1'b1, 4'd0);
    queue_cmd(KIND_SET, 5'd26, 1'b1, 4'd0);
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);
    queue_cmd(KIND_TAKE, 5'd0, 1'b0, 4'd0);
    queue_cmd(KIND_LEVEL, 5'd0, 1'b0, 4'd15);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      gaps_on = (ph < RANDOM_PHASES - 1);
      case (ph)
        0:       write_prio_words(16'h0000, 16'h0000, 16'h0000);
        1:       write_prio_words(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2:       write_prio_words(16'h5555, 16'h5555, 16'h5555);
        default: write_prio_words(random_prio_word(), random_prio_word(), random_prio_word());
      endcase
      repeat (ITEMS_PER_PHASE) cmd_queue.push_back(random_cmd());
    end

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/ipc_pkg.sv
design/ipc_arb.sv
design/ipc_ctrl.sv
design/ipc_dp.sv
design/interrupt_priority_controller_top.sv
verif/testbench.sv
